FILE: hdl/ypab_pkg.sv
// shared types and constants for the ycbcr pair alpha blend / unblend block
// no dependencies
`default_nettype none

package ypab_pkg;

    localparam int BYTE_W     = 8;
    localparam int LANES      = 4;
    localparam int WORD_W     = BYTE_W * LANES;
    localparam int WEIGHT_W   = BYTE_W + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = WORD_W / DIV_STEPS;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = WEIGHT_W'(256);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_COLOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA      = 2'd2;

    localparam logic [BYTE_W-1:0] ALPHA_RESET = 8'd128;

    // per byte lane working state of the divider chain
    typedef struct packed {
        logic [WORD_W-1:0] num;
        logic [BYTE_W-1:0] rem;
        logic [BYTE_W-1:0] quo;
        logic [BYTE_W-1:0] mix;
    } lane_t;

    typedef lane_t [LANES-1:0] word_t;

endpackage

`default_nettype wire

FILE: hdl/ycbcr_pair_alpha_blend_unblend_top.sv
// Constant-alpha blend / unblend of packed YCbCr 4:2:2 pixel pairs.
// Input stream s_*: tdata = pixel_word (Y0 31:24, Y1 23:16, Cb 15:8, Cr 7:0).
// Output stream m_*: tdata = result_word, same byte packing.
// Config port: cfg_we, cfg_index (0 blend_mode, 1 fill_color, 2 alpha), cfg_wdata;
// write only between frames, with no transfer in flight.
// Blend: (color*alpha + pixel*(256-alpha)) >> 8 per byte.
// Unblend: (pixel*256 - color*alpha) mod 2^32 divided by (256-alpha), low byte kept.
// Pipeline: two product/numerator stages, then DIV_STAGES restoring divider stages
// taking two quotient bits each on all four lanes, then the output register.
// Throughput: one pixel pair per clock while the output is not stalled; the divider chain is fully pipelined.
// Stall: the output has a skid entry; s_tready drops only once it is full, and
// the whole pipeline then holds until the receiver takes a transfer.
// Reset: clears all valid bits, blend_mode 0, fill_color 0, alpha 128.
`default_nettype none

module ycbcr_pair_alpha_blend_unblend_top
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [ypab_pkg::WORD_W-1:0]            s_tdata,    // pixel_word
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [ypab_pkg::WORD_W-1:0]                 m_tdata,    // result_word
    input  wire logic                                   cfg_we,
    input  wire logic [ypab_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [ypab_pkg::WORD_W-1:0]            cfg_wdata
);

    logic                                               blend_mode_reg;
    logic [ypab_pkg::WORD_W-1:0]                        fill_color_reg;
    logic [ypab_pkg::BYTE_W-1:0]                        alpha_reg;
    logic [ypab_pkg::WEIGHT_W-1:0]                      weight;
    logic                                               en;
    logic                                               div_valid [ypab_pkg::DIV_STAGES+1];
    ypab_pkg::word_t                                    div_word  [ypab_pkg::DIV_STAGES+1];
    logic [ypab_pkg::WORD_W-1:0]                        result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= 1'b0;
            fill_color_reg <= '0;
            alpha_reg      <= ypab_pkg::ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ypab_pkg::CFG_BLEND_MODE: blend_mode_reg <= cfg_wdata[0];
                ypab_pkg::CFG_FILL_COLOR: fill_color_reg <= cfg_wdata;
                ypab_pkg::CFG_ALPHA:      alpha_reg      <= cfg_wdata[ypab_pkg::BYTE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // 256 - alpha in 9 bits
    assign weight = ypab_pkg::FULL_WEIGHT - {1'b0, alpha_reg};

    ypab_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_pixel   (s_tdata),
        .fill_color (fill_color_reg),
        .alpha      (alpha_reg),
        .weight     (weight),
        .out_valid  (div_valid[0]),
        .out_word   (div_word[0])
    );

    for (genvar g = 0; g < ypab_pkg::DIV_STAGES; g++)
    begin : g_div
        ypab_div_stage u_div_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[g]),
            .in_word   (div_word[g]),
            .divisor   (weight),
            .out_valid (div_valid[g+1]),
            .out_word  (div_word[g+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < ypab_pkg::LANES; i++)
        begin
            result[i*ypab_pkg::BYTE_W +: ypab_pkg::BYTE_W] =
                blend_mode_reg ? div_word[ypab_pkg::DIV_STAGES][i].quo
                               : div_word[ypab_pkg::DIV_STAGES][i].mix;
        end
    end

    ypab_out_skid u_out_skid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid[ypab_pkg::DIV_STAGES]),
        .in_data  (result),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = en;

    // the skid entry only fills while the output register is holding
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output pending");

    // a stalled pipeline keeps its last stage
    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid[ypab_pkg::DIV_STAGES] && !s_tready) |=> div_valid[ypab_pkg::DIV_STAGES])
        else $error("pipeline tail lost during stall");

    // an accepted input transfer passes the s1 and s2 front registers to div_valid[0], unless a stall comes between
    a_front_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 div_valid[0] || !$past(s_tready))
        else $error("accepted transfer missing from pipeline");

endmodule

`default_nettype wire

FILE: hdl/ypab_front.sv
// input stages: per-lane products, then blend byte and wrapped unblend numerator
// depends on ypab_pkg
`default_nettype none

module ypab_front
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [ypab_pkg::WORD_W-1:0]        in_pixel,
    input  wire logic [ypab_pkg::WORD_W-1:0]        fill_color,
    input  wire logic [ypab_pkg::BYTE_W-1:0]        alpha,
    input  wire logic [ypab_pkg::WEIGHT_W-1:0]      weight,
    output logic                                    out_valid,
    output ypab_pkg::word_t                         out_word
);

    localparam int PROD_CA_W = 2 * ypab_pkg::BYTE_W;
    localparam int PROD_PW_W = ypab_pkg::BYTE_W + ypab_pkg::WEIGHT_W;
    localparam int SUM_W     = PROD_PW_W + 1;

    logic                                                  s1_valid_reg;
    logic [ypab_pkg::LANES-1:0][ypab_pkg::BYTE_W-1:0]      s1_pix_reg;
    logic [ypab_pkg::LANES-1:0][PROD_CA_W-1:0]             s1_ca_reg;
    logic [ypab_pkg::LANES-1:0][PROD_PW_W-1:0]             s1_pw_reg;
    logic                                                  s2_valid_reg;
    ypab_pkg::word_t                                       s2_word_reg;
    ypab_pkg::word_t                                       s2_word_next;
    logic [ypab_pkg::LANES-1:0][SUM_W-1:0]                 sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ypab_pkg::LANES; i++)
            begin
                s1_pix_reg[i] <= in_pixel[i*ypab_pkg::BYTE_W +: ypab_pkg::BYTE_W];
                s1_ca_reg[i]  <= fill_color[i*ypab_pkg::BYTE_W +: ypab_pkg::BYTE_W] * alpha;
                s1_pw_reg[i]  <= in_pixel[i*ypab_pkg::BYTE_W +: ypab_pkg::BYTE_W] * weight;
            end
            s2_word_reg <= s2_word_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ypab_pkg::LANES; i++)
        begin
            sum[i] = SUM_W'(s1_ca_reg[i]) + SUM_W'(s1_pw_reg[i]);
            s2_word_next[i].mix = sum[i][ypab_pkg::BYTE_W +: ypab_pkg::BYTE_W];
            // pixel*256 - color*alpha, wrapping modulo 2^32
            s2_word_next[i].num =
                {{(ypab_pkg::WORD_W-PROD_CA_W){1'b0}}, s1_pix_reg[i], {ypab_pkg::BYTE_W{1'b0}}}
                - {{(ypab_pkg::WORD_W-PROD_CA_W){1'b0}}, s1_ca_reg[i]};
            s2_word_next[i].rem = '0;
            s2_word_next[i].quo = '0;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

endmodule

`default_nettype wire

FILE: hdl/ypab_div_stage.sv
// one restoring division stage, DIV_STEPS quotient bits for each byte lane
// depends on ypab_pkg
`default_nettype none

module ypab_div_stage
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire ypab_pkg::word_t                    in_word,
    input  wire logic [ypab_pkg::WEIGHT_W-1:0]      divisor,
    output logic                                    out_valid,
    output ypab_pkg::word_t                         out_word
);

    logic                                           valid_reg;
    ypab_pkg::word_t                                word_reg;
    ypab_pkg::word_t                                word_next;
    logic [ypab_pkg::WEIGHT_W-1:0]                  trial;
    logic [ypab_pkg::WEIGHT_W-1:0]                  diff;
    logic                                           qbit;

    always_comb
    begin
        word_next = in_word;
        trial     = '0;
        diff      = '0;
        qbit      = 1'b0;
        for (int i = 0; i < ypab_pkg::LANES; i++)
        begin
            for (int s = 0; s < ypab_pkg::DIV_STEPS; s++)
            begin
                trial = {word_next[i].rem, word_next[i].num[ypab_pkg::WORD_W-1]};
                diff  = trial - divisor;
                qbit  = (trial >= divisor);
                word_next[i].rem = qbit ? diff[ypab_pkg::BYTE_W-1:0]
                                        : trial[ypab_pkg::BYTE_W-1:0];
                word_next[i].num = {word_next[i].num[ypab_pkg::WORD_W-2:0], 1'b0};
                word_next[i].quo = {word_next[i].quo[ypab_pkg::BYTE_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

FILE: hdl/ypab_out_skid.sv
// output register with a skid entry; its full flag stalls the whole pipeline
// depends on ypab_pkg
`default_nettype none

module ypab_out_skid
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic [ypab_pkg::WORD_W-1:0]        in_data,
    output logic                                    en,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [ypab_pkg::WORD_W-1:0]             m_tdata
);

    logic                                           out_valid_reg;
    logic [ypab_pkg::WORD_W-1:0]                    out_data_reg;
    logic                                           skid_valid_reg;
    logic [ypab_pkg::WORD_W-1:0]                    skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid;
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= in_data;
        end
        else
        begin
            skid_data_reg <= in_data;
        end
    end

    assign en       = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: tb/ycbcr_pair_alpha_blend_unblend_top_tb.sv
// testbench for ycbcr_pair_alpha_blend_unblend_top: directed and random pixel pairs
// checked against a per-byte blend / unblend predictor in both modes
// depends on ypab_pkg and the top level rtl
`timescale 1ns / 100ps

module ycbcr_pair_alpha_blend_unblend_top_tb;

    import ypab_pkg::*;

    localparam logic                   MODE_BLEND   = 1'b0;
    localparam logic                   MODE_UNBLEND = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam int                     IDLE_PCT     = 8;
    localparam int                     STALL_LIMIT  = 2000;
    localparam int                     TAIL_CYCLES  = 25;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata   = '0;     // pixel_word
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [WORD_W-1:0]      m_tdata;            // result_word
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_wdata = '0;

    // shadow copy of the block's registers
    logic                   mode_reg  = MODE_BLEND;
    logic [WORD_W-1:0]      color_reg = '0;
    logic [BYTE_W-1:0]      alpha_reg = ALPHA_RESET;

    logic [WORD_W-1:0]      result_expected_q[$];
    int                     error_count      = 0;
    int                     stall_count      = 0;
    int                     sink_hold_cycles = 0;
    bit                     source_steady    = 1'b0;
    bit                     sink_steady      = 1'b0;

    ycbcr_pair_alpha_blend_unblend_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] blend_pair(input logic [WORD_W-1:0] pix);
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] q;
        res = '0;
        a   = WORD_W'(alpha_reg);
        // pixel weight is 9 bits wide, so alpha zero gives a full 256
        w   = WORD_W'(FULL_WEIGHT) - a;
        for (int ln = 0; ln < LANES; ln++)
        begin
            p = WORD_W'(pix[ln*BYTE_W +: BYTE_W]);
            c = WORD_W'(color_reg[ln*BYTE_W +: BYTE_W]);
            if (mode_reg == MODE_BLEND)
            begin
                q = (c * a + p * w) >> BYTE_W;
            end
            else
            begin
                // wraps modulo 2^32 when the color term is larger
                num = (p << BYTE_W) - c * a;
                q   = num / w;
            end
            res[ln*BYTE_W +: BYTE_W] = q[BYTE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] random_pair();
        logic [WORD_W-1:0] word;
        word = '0;
        for (int ln = 0; ln < LANES; ln++)
        begin
            case ($urandom_range(0, 5))
                0:       word[ln*BYTE_W +: BYTE_W] = 8'h00;
                1:       word[ln*BYTE_W +: BYTE_W] = 8'hff;
                default: word[ln*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
            endcase
        end
        return word;
    endfunction

    // one pixel pair transfer; returns at the accepting edge with s_tvalid still high
    task automatic send_pixel(input logic [WORD_W-1:0] pix);
        if (!source_steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        result_expected_q.push_back(blend_pair(pix));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (result_expected_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_BLEND_MODE: mode_reg  = val[0];
            CFG_FILL_COLOR: color_reg = val;
            CFG_ALPHA:      alpha_reg = val[BYTE_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic mode, input logic [WORD_W-1:0] color,
                              input logic [BYTE_W-1:0] alpha);
        drain_pipeline();
        write_reg(CFG_BLEND_MODE, WORD_W'(mode));
        write_reg(CFG_FILL_COLOR, color);
        write_reg(CFG_ALPHA, WORD_W'(alpha));
    endtask

    task automatic test_reset_state();
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h807f_01fe);
        drain_pipeline();
    endtask

    task automatic test_blend_extremes();
        set_config(MODE_BLEND, 32'hffff_ffff, 8'd255);
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        set_config(MODE_BLEND, 32'h0000_0000, 8'd1);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h0000_0000);
        set_config(MODE_BLEND, 32'h12ed_807f, 8'd255);
        send_pixel(32'ha55a_00ff);
        drain_pipeline();
    endtask

    task automatic test_unblend_extremes();
        // full alpha divides by one; zero pixel under a bright color goes negative
        set_config(MODE_UNBLEND, 32'hffff_ffff, 8'd255);
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        set_config(MODE_UNBLEND, 32'h0000_0000, 8'd1);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h00ff_7f80);
        set_config(MODE_UNBLEND, 32'h00ff_8001, 8'd128);
        send_pixel(32'hff00_40ff);
        drain_pipeline();
    endtask

    task automatic test_alpha_zero();
        // alpha zero leaves the pixel unchanged in both modes
        set_config(MODE_UNBLEND, 32'hffff_ffff, 8'd0);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h3c96_0a5f);
        set_config(MODE_BLEND, 32'hffff_ffff, 8'd0);
        send_pixel(32'h3c96_0a5f);
        drain_pipeline();
    endtask

    task automatic test_unused_index();
        set_config(MODE_BLEND, 32'h5a5a_a5a5, 8'd77);
        write_reg(CFG_UNUSED, 32'hffff_ffff);
        send_pixel(32'hc3c3_3c3c);
        drain_pipeline();
        write_reg(CFG_UNUSED, 32'h0000_0000);
        send_pixel(32'h0000_ffff);
        drain_pipeline();
    endtask

    task automatic test_random_streams();
        logic [BYTE_W-1:0] alpha;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       alpha = 8'd1;
                1:       alpha = 8'd255;
                default: alpha = BYTE_W'($urandom_range(1, 255));
            endcase
            set_config(phase % 2 ? MODE_UNBLEND : MODE_BLEND, random_pair(), alpha);
            source_steady = (phase == 3);
            sink_steady   = (phase == 3);
            repeat (90) send_pixel(random_pair());
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        drain_pipeline();
    endtask

    task automatic test_output_stall();
        set_config(MODE_UNBLEND, random_pair(), BYTE_W'($urandom_range(1, 255)));
        source_steady    = 1'b1;
        sink_hold_cycles = 300;
        repeat (150) send_pixel(random_pair());
        source_steady = 1'b0;
        drain_pipeline();
    endtask

    // result checker and output ready pattern
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] exp_word;
        if (m_tvalid && m_tready)
        begin
            if (result_expected_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp_word = result_expected_q.pop_front();
                if (m_tdata !== exp_word)
                begin
                    $display("%0t: result_word mismatch, expected %h, actual %h",
                             $time, exp_word, m_tdata);
                    error_count++;
                end
            end
        end
        if (sink_hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            sink_hold_cycles--;
        end
        else
        begin
            m_tready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, stall_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_blend_extremes();
        test_unblend_extremes();
        test_alpha_zero();
        test_unused_index();
        test_random_streams();
        test_output_stall();
        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (result_expected_q.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, result_expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
